/* src/sha1s_pkg.sv */
// Shared types and constants for the SHA-1 stream hasher.
`timescale 1ns / 1ps

package sha1s_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       last;
    } in_beat_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_beat_t;

    typedef logic [4:0][31:0]  chain_t;
    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cmp_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KICK,
        ST_COMP,
        ST_PAD,
        ST_OUT
    } state_t;

    localparam chain_t H_INIT = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_0 = 32'h5A827999;
    localparam logic [31:0] K_1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_3 = 32'hCA62C1D6;

    localparam logic [6:0] RND_LAST  = 7'd79;
    localparam logic [6:0] RND_PH1   = 7'd20;
    localparam logic [6:0] RND_PH2   = 7'd40;
    localparam logic [6:0] RND_PH3   = 7'd60;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] FILL_LEN  = 6'd56;
    localparam logic [5:0] FILL_LAST = 6'd63;
    localparam logic [3:0] LEN_HI    = 4'd14;
    localparam logic [3:0] LEN_LO    = 4'd15;
    localparam logic [2:0] WORD_LAST = 3'd4;

endpackage

/* src/sha1s_compress.sv */
// Iterative SHA-1 compression: one round per cycle over a rolling schedule window.
`timescale 1ns / 1ps

module sha1s_compress (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  sha1s_pkg::block_t     block_i,
    input  sha1s_pkg::chain_t     chain_i,
    output sha1s_pkg::cmp_status_t status_o,
    output sha1s_pkg::chain_t     work_o
);
    import sha1s_pkg::*;

    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  rnd_reg;
    chain_t      work_reg;
    block_t      sched_reg;

    logic [31:0] a_w, b_w, c_w, d_w, e_w;
    logic [31:0] f_w, k_w, t_w, w_new;

    always_comb begin
        a_w = work_reg[0];
        b_w = work_reg[1];
        c_w = work_reg[2];
        d_w = work_reg[3];
        e_w = work_reg[4];
        if (rnd_reg < RND_PH1) begin
            f_w = (b_w & c_w) | (~b_w & d_w);
            k_w = K_0;
        end else if (rnd_reg < RND_PH2) begin
            f_w = b_w ^ c_w ^ d_w;
            k_w = K_1;
        end else if (rnd_reg < RND_PH3) begin
            f_w = (b_w & c_w) | (b_w & d_w) | (c_w & d_w);
            k_w = K_2;
        end else begin
            f_w = b_w ^ c_w ^ d_w;
            k_w = K_3;
        end
        t_w = {a_w[26:0], a_w[31:27]} + f_w + e_w + k_w + sched_reg[0];
        w_new = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            rnd_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end else if (busy_reg) begin
                if (rnd_reg == RND_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                rnd_reg <= rnd_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg  <= chain_i;
            sched_reg <= block_i;
        end else if (busy_reg) begin
            work_reg[4] <= d_w;
            work_reg[3] <= c_w;
            work_reg[2] <= {b_w[1:0], b_w[31:2]};
            work_reg[1] <= a_w;
            work_reg[0] <= t_w;
            for (int i = 0; i < 15; i++) begin
                sched_reg[i] <= sched_reg[i + 1];
            end
            sched_reg[15] <= {w_new[30:0], w_new[31]};
        end
    end

    assign status_o.busy = busy_reg;
    assign status_o.done = done_reg;
    assign work_o        = work_reg;

endmodule

/* src/sha1_stream_hasher.sv */
// SHA-1 stream hasher top level: byte packing, padding sequencer and digest output.
//
// Input channel s_*: one beat carries one message byte (byte_present = 1) or none;
// a beat with last = 1 closes the message. Output channel m_*: five beats per
// message, digest words h0..h4 in order, last_word set on h4.
// A byte beat that neither completes a 64-byte block nor closes the message keeps
// s_ready high. A beat that completes a block starts a compression: a load, then
// the 80 SHA-1 rounds, one per cycle through the single round unit, then the chain
// update.
// Closing: padding bytes go into the block one per cycle, then one compression
// (two when the length field does not fit), then the five digest beats, one per
// cycle while m_ready is high.
// s_ready is low from the acceptance of a block-completing or closing beat until
// the block is ready for the next beat. While the receiver stalls, m_data holds
// and no input is taken.
// Reset (aresetn low at a clock edge) loads the initial chaining words, clears
// the byte and length counts and drops any message in flight.
`timescale 1ns / 1ps

module sha1_stream_hasher (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sha1s_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output sha1s_pkg::out_beat_t m_data
);
    import sha1s_pkg::*;

    state_t      state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    chain_t      chain_reg, chain_next;
    logic        closing_reg, closing_next;
    logic        first_pad_reg, first_pad_next;
    logic        final_reg, final_next;
    logic [2:0]  out_idx_reg, out_idx_next;
    block_t      blk_buf_reg;

    logic        push_en;
    logic [7:0]  push_byte;
    logic        len_we;
    logic        start;
    cmp_status_t cmp_status;
    chain_t      cmp_work;

    sha1s_compress u_compress (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start),
        .block_i  (blk_buf_reg),
        .chain_i  (chain_reg),
        .status_o (cmp_status),
        .work_o   (cmp_work)
    );

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        bits_next      = bits_reg;
        chain_next     = chain_reg;
        closing_next   = closing_reg;
        first_pad_next = first_pad_reg;
        final_next     = final_reg;
        out_idx_next   = out_idx_reg;
        push_en        = 1'b0;
        push_byte      = 8'h00;
        len_we         = 1'b0;
        start          = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.byte_present) begin
                        push_en   = 1'b1;
                        push_byte = s_data.data_byte;
                        bits_next = bits_reg + 64'd8;
                    end
                    if (s_data.byte_present && fill_reg == FILL_LAST) begin
                        state_next     = ST_KICK;
                        closing_next   = s_data.last;
                        first_pad_next = s_data.last;
                    end else if (s_data.last) begin
                        state_next     = ST_PAD;
                        closing_next   = 1'b1;
                        first_pad_next = 1'b1;
                    end
                end
            end
            ST_KICK: begin
                start      = 1'b1;
                state_next = ST_COMP;
            end
            ST_COMP: begin
                if (cmp_status.done) begin
                    for (int i = 0; i < 5; i++) begin
                        chain_next[i] = chain_reg[i] + cmp_work[i];
                    end
                    if (final_reg) begin
                        state_next = ST_OUT;
                    end else if (closing_reg) begin
                        state_next = ST_PAD;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD: begin
                if (first_pad_reg) begin
                    push_en        = 1'b1;
                    push_byte      = PAD_BYTE;
                    first_pad_next = 1'b0;
                    if (fill_reg == FILL_LAST) begin
                        state_next = ST_KICK;
                    end
                end else if (fill_reg == FILL_LEN) begin
                    len_we     = 1'b1;
                    final_next = 1'b1;
                    state_next = ST_KICK;
                end else begin
                    push_en = 1'b1;
                    if (fill_reg == FILL_LAST) begin
                        state_next = ST_KICK;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (out_idx_reg == WORD_LAST) begin
                        chain_next     = H_INIT;
                        fill_next      = '0;
                        bits_next      = '0;
                        closing_next   = 1'b0;
                        first_pad_next = 1'b0;
                        final_next     = 1'b0;
                        out_idx_next   = '0;
                        state_next     = ST_IDLE;
                    end else begin
                        out_idx_next = out_idx_reg + 3'd1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        if (push_en) begin
            fill_next = fill_reg + 6'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            bits_reg      <= '0;
            chain_reg     <= H_INIT;
            closing_reg   <= 1'b0;
            first_pad_reg <= 1'b0;
            final_reg     <= 1'b0;
            out_idx_reg   <= '0;
        end else begin
            fill_reg      <= fill_next;
            bits_reg      <= bits_next;
            chain_reg     <= chain_next;
            closing_reg   <= closing_next;
            first_pad_reg <= first_pad_next;
            final_reg     <= final_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // pack bytes big-endian into the word at the fill position
    always_ff @(posedge aclk) begin
        if (push_en) begin
            case (fill_reg[1:0])
                2'd0:    blk_buf_reg[fill_reg[5:2]]        <= {push_byte, 24'h000000};
                2'd1:    blk_buf_reg[fill_reg[5:2]][23:16] <= push_byte;
                2'd2:    blk_buf_reg[fill_reg[5:2]][15:8]  <= push_byte;
                default: blk_buf_reg[fill_reg[5:2]][7:0]   <= push_byte;
            endcase
        end
        if (len_we) begin
            blk_buf_reg[LEN_HI] <= bits_reg[63:32];
            blk_buf_reg[LEN_LO] <= bits_reg[31:0];
        end
    end

    assign s_ready            = (state_reg == ST_IDLE);
    assign m_valid            = (state_reg == ST_OUT);
    assign m_data.digest_word = chain_reg[out_idx_reg];
    assign m_data.word_index  = out_idx_reg;
    assign m_data.last_word   = (out_idx_reg == WORD_LAST);

endmodule
